### design/assert_macros.svh
// assertion macros shared by the page split write sequencer modules
// expects signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define PSWS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check, live in every cycle
`define PSWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/psws_pkg.sv
// types, codes and constants of the page split write sequencer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package psws_pkg;

  // default page size in bytes and reset value of the wait register
  localparam int PSWS_PAGE_BYTES = 16;
  localparam logic [15:0] PSWS_WAIT_RESET = 16'd5;

  // word kinds
  localparam logic OP_POLL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // sequencer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_START = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;

  // reported status
  localparam logic [1:0] ST_SUCCESS = 2'd0;
  localparam logic [1:0] ST_BUSY    = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  // one input word
  typedef struct packed {
    logic        opcode;
    logic [7:0]  bus_port;
    logic [15:0] start_address;
    logic [15:0] total_length;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0]  status;
    logic        chunk_valid;
    logic [7:0]  chunk_port;
    logic [15:0] chunk_address;
    logic [15:0] chunk_length;
    logic [15:0] chunk_offset;
  } result_t;

endpackage

`default_nettype wire

### design/psws_core.sv
// sequencer state, wait register and chunk split logic
// depends on psws_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module psws_core
  import psws_pkg::*;
#(
  parameter int PAGE_BYTES = PSWS_PAGE_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        item_valid,
  input  wire item_t       item,
  output result_t          result
);

  localparam logic [8:0]  PAGE_W   = 9'(PAGE_BYTES);
  localparam logic [16:0] PAGE_W17 = 17'(PAGE_BYTES);

  logic [15:0] wait_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] done_r, done_nxt;
  logic [15:0] elap_r, elap_nxt;

  logic [7:0]  lo_tab [256];
  logic [7:0]  hi_tab [256];
  logic        is_idle;
  logic [15:0] cur_addr;
  logic [15:0] cur_left;
  logic [15:0] cur_done;
  logic [1:0]  cur_phase;
  logic [8:0]  off_sum;
  logic [8:0]  page_off;
  logic [8:0]  page_room;
  logic        fits_page;
  logic [15:0] chunk_size;

  // remainder tables: low byte mod page, high byte times 256 mod page
  for (genvar g = 0; g < 256; g++) begin : g_mod_tab
    assign lo_tab[g] = 8'(g % PAGE_BYTES);
    assign hi_tab[g] = 8'((g * 256) % PAGE_BYTES);
  end

  // working request: an idle poll takes the new request from the word
  assign is_idle   = (phase_r == PH_IDLE);
  assign cur_addr  = is_idle ? item.start_address : addr_r;
  assign cur_left  = is_idle ? item.total_length  : left_r;
  assign cur_done  = is_idle ? 16'd0             : done_r;
  assign cur_phase = is_idle ? PH_START          : phase_r;

  // offset within the page and the chunk that stays inside it
  assign off_sum    = {1'b0, hi_tab[cur_addr[15:8]]} + {1'b0, lo_tab[cur_addr[7:0]]};
  assign page_off   = (off_sum >= PAGE_W) ? (off_sum - PAGE_W) : off_sum;
  assign page_room  = PAGE_W - page_off;
  assign fits_page  = (({8'd0, page_off} + {1'b0, cur_left}) < PAGE_W17);
  assign chunk_size = fits_page ? cur_left : {7'd0, page_room};

  // next state and result for the word in the input register
  always_comb begin
    phase_nxt = phase_r;
    addr_nxt  = addr_r;
    left_nxt  = left_r;
    done_nxt  = done_r;
    elap_nxt  = elap_r;
    result    = '0;
    if (item.opcode == OP_TICK) begin
      if (elap_r != 16'hFFFF) begin
        elap_nxt = elap_r + 16'd1;
      end
      result.status = is_idle ? ST_SUCCESS : ST_BUSY;
    end else begin
      addr_nxt = cur_addr;
      left_nxt = cur_left;
      done_nxt = cur_done;
      unique case (cur_phase)
        PH_START: begin
          if (cur_left != 16'd0) begin
            result.status        = ST_BUSY;
            result.chunk_valid   = 1'b1;
            result.chunk_port    = item.bus_port;
            result.chunk_address = cur_addr;
            result.chunk_length  = chunk_size;
            result.chunk_offset  = cur_done;
            left_nxt  = cur_left - chunk_size;
            addr_nxt  = cur_addr + chunk_size;
            done_nxt  = cur_done + chunk_size;
            elap_nxt  = 16'd0;
            phase_nxt = PH_WAIT;
          end else begin
            result.status = ST_ERROR;
            phase_nxt     = PH_IDLE;
          end
        end
        PH_WAIT: begin
          if (elap_r < wait_r) begin
            result.status = ST_BUSY;
          end else if (cur_left != 16'd0) begin
            result.status = ST_BUSY;
            phase_nxt     = PH_START;
          end else begin
            result.status = ST_SUCCESS;
            phase_nxt     = PH_IDLE;
          end
        end
        default: begin
          result.status = ST_ERROR;
          phase_nxt     = PH_IDLE;
        end
      endcase
    end
  end

  // state registers, updated once per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      addr_r  <= '0;
      left_r  <= '0;
      done_r  <= '0;
      elap_r  <= '0;
    end else if (item_valid) begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      left_r  <= left_nxt;
      done_r  <= done_nxt;
      elap_r  <= elap_nxt;
    end
  end

  // wait length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wait_r <= PSWS_WAIT_RESET;
    end else if (cfg_wr_en) begin
      wait_r <= cfg_wr_data;
    end
  end

  // checks
  `PSWS_ASSERT_RST(a_chunk_starts_wait, rst_n && item_valid && result.chunk_valid |=> phase_r == PH_WAIT && elap_r == 16'd0, "chunk issued without entering wait")
  `PSWS_ASSERT(a_chunk_nonempty, rst_n && item_valid && result.chunk_valid |-> result.chunk_length != 16'd0, "empty chunk issued")
  `PSWS_ASSERT_RST(a_tick_keeps_phase, rst_n && item_valid && item.opcode == OP_TICK |=> phase_r == $past(phase_r), "tick changed the phase")

endmodule

`default_nettype wire

### design/page_split_write_sequencer.sv
// Page split write sequencer: one result word for every input word.
// Words pass the input register, the state logic and the output register in turn.
// Throughput: one word per cycle unless the result side stalls.
// The input side keeps taking words while a result waits, as long as the result moves.
// Reset (rst_n low, synchronous): idle phase, counters zero, wait ticks 5, no words held.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module page_split_write_sequencer
  import psws_pkg::*;
#(
  parameter int PAGE_BYTES = PSWS_PAGE_BYTES
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  // input words
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // bus_port, start_address, total_length
  input  wire logic        in_tuser,   // opcode
  // result words
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // status, chunk_port, chunk_address,
                                       // chunk_length, chunk_offset, zero fill
  output logic             out_tuser   // chunk_valid
);

  logic    s1_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  result_t core_res;
  logic    out_free;
  logic    s1_adv;
  logic    in_acc;

  // handshake control
  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  // input register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.opcode        <= in_tuser;
      item_r.bus_port      <= in_tdata[7:0];
      item_r.start_address <= in_tdata[23:8];
      item_r.total_length  <= in_tdata[39:24];
    end
  end

  // sequencer state and chunk split
  psws_core #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_valid  (s1_adv),
    .item        (item_r),
    .result      (core_res)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= core_res;
    end
  end

  // result word packing
  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.chunk_valid;
  assign out_tdata  = {6'd0, res_r.chunk_offset, res_r.chunk_length,
                       res_r.chunk_address, res_r.chunk_port, res_r.status};

  // checks
  `PSWS_ASSERT_RST(a_adv_fills_out, rst_n && s1_adv |=> out_tvalid, "word moved on but no result shown")
  `PSWS_ASSERT_RST(a_no_drop_on_stall, rst_n && out_valid_r && !out_tready |=> out_valid_r && !$past(s1_adv), "result overwritten while stalled")

endmodule

`default_nettype wire

### tb/tb_page_split_write_sequencer.sv
// testbench for the page split write sequencer: a directed table, a wrapped request, a long wait
// and random request traffic, each result checked against a table row or a behavioral model
// depends on psws_pkg and page_split_write_sequencer
`timescale 1ns / 1ps

module tb_page_split_write_sequencer;
  import psws_pkg::*;

  localparam int PAGE = PSWS_PAGE_BYTES;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 360;
  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_PHASES = 5;

  // one row of the directed table
  typedef struct {
    item_t   word;
    bit      typed;
    result_t want;
  } plan_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic        out_tuser;

  // model of the sequencer state and its wait register
  logic [1:0]  seq_phase;
  logic [15:0] seq_addr;
  logic [15:0] seq_left;
  logic [15:0] seq_done;
  logic [15:0] seq_elapsed;
  logic [15:0] wait_ticks;

  result_t   pending_q[$];
  plan_row_t plan[$];
  int        fail_count;
  int        cycle_count;
  int        rx_stall;
  bit        quiet;
  bit        tx_calm;
  bit        rx_calm;
  bit        hold_req;
  bit        hold_done;

  page_split_write_sequencer #(
    .PAGE_BYTES(PAGE)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("page_split_write_sequencer test failed");
      $finish;
    end
  end

  function automatic item_t mk_item(logic op, logic [7:0] port, logic [15:0] addr,
                                    logic [15:0] len);
    item_t w;
    w.opcode = op;
    w.bus_port = port;
    w.start_address = addr;
    w.total_length = len;
    return w;
  endfunction

  function automatic result_t mk_result(logic [1:0] st, logic v, logic [7:0] port,
                                        logic [15:0] addr, logic [15:0] len,
                                        logic [15:0] off);
    result_t r;
    r.status = st;
    r.chunk_valid = v;
    r.chunk_port = port;
    r.chunk_address = addr;
    r.chunk_length = len;
    r.chunk_offset = off;
    return r;
  endfunction

  function automatic plan_row_t mk_row(item_t w, bit typed, result_t want);
    plan_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = want;
    return row;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // advance the sequencer model by one word and return the result it gives
  function automatic result_t step_sequencer(item_t w);
    result_t r;
    int      first;
    int      last;
    logic [15:0] size;
    r = '0;
    if (w.opcode == OP_TICK) begin
      if (seq_elapsed != 16'hFFFF) seq_elapsed++;
      r.status = (seq_phase == PH_IDLE) ? ST_SUCCESS : ST_BUSY;
      return r;
    end
    // an idle poll latches a new request and falls through to the first chunk
    if (seq_phase == PH_IDLE) begin
      seq_addr = w.start_address;
      seq_left = w.total_length;
      seq_done = '0;
      seq_phase = PH_START;
    end
    case (seq_phase)
      PH_START: begin
        if (seq_left != 0) begin
          // split at the page end, using the unwrapped end address
          first = int'(seq_addr);
          last = first + int'(seq_left);
          if (first / PAGE == last / PAGE) size = seq_left;
          else size = 16'((first / PAGE + 1) * PAGE - first);
          r.chunk_valid = 1'b1;
          r.chunk_port = w.bus_port;
          r.chunk_address = seq_addr;
          r.chunk_length = size;
          r.chunk_offset = seq_done;
          seq_left = seq_left - size;
          seq_addr = seq_addr + size;
          seq_done = seq_done + size;
          seq_elapsed = '0;
          seq_phase = PH_WAIT;
          r.status = ST_BUSY;
        end else begin
          seq_phase = PH_IDLE;
          r.status = ST_ERROR;
        end
      end
      PH_WAIT: begin
        if (seq_elapsed < wait_ticks) begin
          r.status = ST_BUSY;
        end else if (seq_left != 0) begin
          seq_phase = PH_START;
          r.status = ST_BUSY;
        end else begin
          seq_phase = PH_IDLE;
          r.status = ST_SUCCESS;
        end
      end
      default: begin
        seq_phase = PH_IDLE;
        r.status = ST_ERROR;
      end
    endcase
    return r;
  endfunction

  // random word shaped by the model state so requests run to completion
  function automatic item_t random_word();
    item_t w;
    int    pick;
    w = mk_item(OP_POLL, 8'($urandom), 16'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (seq_phase == PH_IDLE) begin
      if (pick < 10) begin
        w.opcode = OP_TICK;
      end else begin
        // some requests start near the top of the address space to wrap
        if ($urandom_range(0, 4) == 0) w.start_address[15:4] = 12'hFFF;
        pick = $urandom_range(0, 99);
        if (pick < 5) w.total_length = '0;
        else if (pick < 75) w.total_length = 16'($urandom_range(1, 48));
        else w.total_length = 16'($urandom_range(49, 300));
      end
    end else if (seq_phase == PH_WAIT && seq_elapsed < wait_ticks) begin
      if (pick < 75) w.opcode = OP_TICK;
    end else if (pick < 15) begin
      w.opcode = OP_TICK;
    end
    return w;
  endfunction

  // offer one word, wait for it to be taken, then record what it should produce
  task automatic send_word(input item_t w, input bit typed, input result_t want);
    int      gap;
    result_t r;
    gap = (quiet || tx_calm) ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {w.total_length, w.start_address, w.bus_port};
    in_tuser <= w.opcode;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    r = step_sequencer(w);
    pending_q.push_back(typed ? want : r);
  endtask

  // drop valid and let every outstanding result drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_wait(input logic [15:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    wait_ticks = value;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  // result side ready with random stalls and one long hold-off
  always @(posedge clk) begin
    if (cycle_count % 128 == 0) rx_calm = ($urandom_range(0, 3) == 0);
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      rx_stall = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet && !rx_calm && $urandom_range(0, 3) == 0) rx_stall = gap_len();
    end
  end

  // compare each taken result word with the oldest expectation
  always @(negedge clk) begin : check_word
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.chunk_port = out_tdata[9:2];
      got.chunk_address = out_tdata[25:10];
      got.chunk_length = out_tdata[41:26];
      got.chunk_offset = out_tdata[57:42];
      got.chunk_valid = out_tuser;
      if (pending_q.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        check_field("status", want.status, got.status);
        check_field("chunk_valid", want.chunk_valid, got.chunk_valid);
        check_field("chunk_port", want.chunk_port, got.chunk_port);
        check_field("chunk_address", want.chunk_address, got.chunk_address);
        check_field("chunk_length", want.chunk_length, got.chunk_length);
        check_field("chunk_offset", want.chunk_offset, got.chunk_offset);
      end
    end
  end

  initial begin
    item_t       w;
    int          waits [RANDOM_PHASES];
    logic [15:0] ones;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_POLL;
    out_tready = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    rx_stall = 0;
    quiet = 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    seq_phase = PH_IDLE;
    seq_addr = '0;
    seq_left = '0;
    seq_done = '0;
    seq_elapsed = '0;
    wait_ticks = PSWS_WAIT_RESET;
    ones = 16'hFFFF;

    // directed table, run with the reset wait of five ticks
    plan.push_back(mk_row(mk_item(OP_TICK, 8'h00, 16'h0000, 16'h0000), 1,
                          mk_result(ST_SUCCESS, 0, 0, 0, 0, 0)));
    plan.push_back(mk_row(mk_item(OP_POLL, 8'h12, 16'h1234, 16'h0000), 1,
                          mk_result(ST_ERROR, 0, 0, 0, 0, 0)));
    // top address: one byte up to the wrap, the rest from address zero
    plan.push_back(mk_row(mk_item(OP_POLL, 8'hFF, ones, 16'd17), 1,
                          mk_result(ST_BUSY, 1, 8'hFF, ones, 16'd1, 16'd0)));
    plan.push_back(mk_row(mk_item(OP_POLL, 8'h00, 16'h0000, 16'h0000), 1,
                          mk_result(ST_BUSY, 0, 0, 0, 0, 0)));
    repeat (5) plan.push_back(mk_row(mk_item(OP_TICK, 8'hFF, ones, ones), 1,
                                     mk_result(ST_BUSY, 0, 0, 0, 0, 0)));
    plan.push_back(mk_row(mk_item(OP_POLL, 8'h00, 16'h0000, 16'h0000), 1,
                          mk_result(ST_BUSY, 0, 0, 0, 0, 0)));
    plan.push_back(mk_row(mk_item(OP_POLL, 8'hA5, 16'h5A5A, 16'hA5A5), 0, '0));
    plan.push_back(mk_row(mk_item(OP_TICK, 8'h3C, 16'hC3C3, 16'h3C3C), 1,
                          mk_result(ST_BUSY, 0, 0, 0, 0, 0)));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) send_word(plan[i].word, plan[i].typed, plan[i].want);
    settle();

    // finish the wrapped request with no wait between chunks
    write_wait(16'd0);
    quiet = 1'b1;
    while (seq_phase != PH_IDLE) begin
      w = mk_item(OP_POLL, 8'($urandom), 16'($urandom), 16'($urandom));
      send_word(w, 0, '0);
    end
    settle();

    // longer wait: busy one tick short of it, done once it has passed
    write_wait(16'd64);
    w = mk_item(OP_POLL, 8'($urandom), {12'($urandom), 4'h0}, 16'(PAGE));
    send_word(w, 0, '0);
    repeat (63) send_word(mk_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom)),
                          0, '0);
    send_word(mk_item(OP_POLL, 8'($urandom), 16'($urandom), 16'($urandom)), 0, '0);
    repeat (3) send_word(mk_item(OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom)),
                         0, '0);
    send_word(mk_item(OP_POLL, 8'($urandom), 16'($urandom), 16'($urandom)), 0, '0);
    settle();
    quiet = 1'b0;

    // random request traffic over several wait settings
    waits[0] = 0;
    waits[1] = 1;
    waits[2] = 3;
    waits[3] = $urandom_range(4, 12);
    waits[4] = PSWS_WAIT_RESET;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_wait(16'(waits[p]));
      if (p == 0) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) tx_calm = ($urandom_range(0, 3) == 0);
        send_word(random_word(), 0, '0);
      end
      settle();
    end

    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("page_split_write_sequencer test passed");
    end else begin
      $display("page_split_write_sequencer test failed");
    end
    $finish;
  end

endmodule

### page_split_write_sequencer.f
+incdir+design
design/psws_pkg.sv
design/psws_core.sv
design/page_split_write_sequencer.sv
tb/tb_page_split_write_sequencer.sv
